FILE: hdl/assert_macros.svh
// Assertion helpers shared by the classifier RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define AIC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define AIC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/aic_pkg.sv
// Shared types and constants for the instruction classifier.
// No dependencies; imported by every module of the block.
package aic_pkg;

   // Instruction class codes
   typedef enum logic [3:0] {
      KIND_UNKNOWN = 4'd0,
      KIND_ADRP    = 4'd1,
      KIND_BL      = 4'd2,
      KIND_CBZ     = 4'd3,
      KIND_RET     = 4'd4,
      KIND_TBNZ    = 4'd5,
      KIND_ADD     = 4'd6,
      KIND_BR      = 4'd7,
      KIND_LDR     = 4'd8,
      KIND_CBNZ    = 4'd9
   } kind_type;

   // Load addressing form codes
   typedef enum logic [1:0] {
      FORM_GENERAL   = 2'd0,
      FORM_REGISTER  = 2'd1,
      FORM_IMMEDIATE = 2'd2,
      FORM_LITERAL   = 2'd3
   } form_type;

   // Opcode patterns
   localparam logic [4:0]  OP_ADRP     = 5'b10000;
   localparam logic [4:0]  OP_ADD      = 5'b10001;
   localparam logic [5:0]  OP_BL       = 6'b100101;
   localparam logic [6:0]  OP_CBZ      = 7'b0110100;
   localparam logic [6:0]  OP_TBNZ     = 7'b0110111;
   localparam logic [6:0]  OP_CBNZ     = 7'b0110101;
   localparam logic [31:0] OP_RET      = 32'b11010110010111110000001111100000;
   localparam logic [31:0] OP_BR       = 32'b11010110000111110000001111100000;
   localparam logic [31:0] RN_MASK     = 32'h0000_03E0;
   localparam logic [7:0]  OP_LDR_REG  = 8'hE1;
   localparam logic [7:0]  OP_LDR_UIMM = 8'hE5;
   localparam logic [8:0]  OP_LDR_LIT  = 9'b000011000;
   localparam logic [1:0]  OPT_REG     = 2'b10;

   // Accepted word in flight between the input stage and the decoder
   typedef struct packed {
      logic [31:0] word;
      logic [63:0] pc;
   } stage_type;

   // Decoded result word
   typedef struct packed {
      kind_type    kind;
      form_type    load_form;
      logic        is_branch_imm;
      logic [63:0] immediate;
      logic        imm_valid;
      logic [4:0]  dest_reg;
      logic        dest_valid;
      logic [4:0]  base_reg;
      logic        base_valid;
      logic [4:0]  test_reg;
      logic        test_valid;
   } result_type;

endpackage

FILE: hdl/aic_in_stage.sv
// Input register of the classifier: captures the word and forms pc.
// Depends on aic_pkg.
module aic_in_stage
   import aic_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_instr_word,
   input  logic [63:0] req_location,
   input  logic [63:0] slide,
   input  logic        take,
   output logic        stage_valid,
   output stage_type   stage
);

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic      accept;

   // Take a new word when empty or when the held word moves on
   assign req_ready = !valid_ff || take;
   assign accept    = req_valid && req_ready;

   assign valid_in       = accept || (valid_ff && !take);
   assign stage_in.word  = req_instr_word;
   assign stage_in.pc    = req_location + slide;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload only on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

FILE: hdl/aic_decode.sv
// Combinational decode of one instruction word into a result word.
// Depends on aic_pkg.
module aic_decode
   import aic_pkg::*;
(
   input  stage_type  stage,
   output result_type result
);

   logic [31:0] w;
   logic [7:0]  ldr_top;
   logic        ldr_reg_hit;
   logic        ldr_uimm_hit;
   logic        ldr_lit_hit;
   kind_type    kind;

   assign w = stage.word;
   assign ldr_top      = w[29:22];
   assign ldr_reg_hit  = w[31] && (ldr_top == OP_LDR_REG);
   assign ldr_uimm_hit = w[31] && (ldr_top == OP_LDR_UIMM);
   assign ldr_lit_hit  = (w[31:23] == OP_LDR_LIT);

   // Classify in fixed priority order
   always_comb begin
      priority if (w[28:24] == OP_ADRP && w[31])          kind = KIND_ADRP;
      else if (w[28:24] == OP_ADD)                        kind = KIND_ADD;
      else if (w[31:26] == OP_BL)                         kind = KIND_BL;
      else if (w[30:24] == OP_CBZ)                        kind = KIND_CBZ;
      else if ((w | RN_MASK) == OP_RET)                   kind = KIND_RET;
      else if (w[30:24] == OP_TBNZ)                       kind = KIND_TBNZ;
      else if ((w | RN_MASK) == OP_BR)                    kind = KIND_BR;
      else if ((ldr_reg_hit && w[11:10] != 2'b00) || ldr_uimm_hit || ldr_lit_hit)
                                                          kind = KIND_LDR;
      else if (w[30:24] == OP_CBNZ)                       kind = KIND_CBNZ;
      else                                                kind = KIND_UNKNOWN;
   end

   // Build fields for the class
   always_comb begin
      result               = '0;
      result.kind          = kind;
      result.load_form     = FORM_GENERAL;
      unique case (kind)
         KIND_ADRP: begin
            result.immediate  = {stage.pc[63:12], 12'd0}
                              + {{31{w[23]}}, w[23:5], w[30:29], 12'd0};
            result.imm_valid  = 1'b1;
            result.dest_reg   = w[4:0];
            result.dest_valid = 1'b1;
         end
         KIND_ADD: begin
            result.immediate  = w[22] ? {28'd0, w[21:10], 24'd0} >> 12
                                      : {52'd0, w[21:10]};
            result.imm_valid  = 1'b1;
            result.dest_reg   = w[4:0];
            result.dest_valid = 1'b1;
            result.base_reg   = w[9:5];
            result.base_valid = 1'b1;
         end
         KIND_BL: begin
            result.immediate     = {{38{w[25]}}, w[25:0]};
            result.imm_valid     = 1'b1;
            result.is_branch_imm = 1'b1;
         end
         KIND_CBZ, KIND_CBNZ: begin
            result.immediate     = {{45{w[23]}}, w[23:5]};
            result.imm_valid     = 1'b1;
            result.is_branch_imm = 1'b1;
            result.test_reg      = w[4:0];
            result.test_valid    = 1'b1;
         end
         KIND_TBNZ: begin
            result.immediate     = {{50{w[18]}}, w[18:5]};
            result.imm_valid     = 1'b1;
            result.is_branch_imm = 1'b1;
            result.test_reg      = w[4:0];
            result.test_valid    = 1'b1;
         end
         KIND_RET, KIND_BR: begin
            result.base_reg   = w[9:5];
            result.base_valid = 1'b1;
         end
         KIND_LDR: begin
            priority if (ldr_reg_hit && w[11:10] == OPT_REG) begin
               result.load_form = FORM_REGISTER;
            end else if (w[31]) begin
               result.load_form = FORM_IMMEDIATE;
               result.imm_valid = 1'b1;
               // Unsigned scaled offset, else signed unscaled offset
               if (w[25:24] != 2'b00) begin
                  result.immediate = {52'd0, w[21:10]} << w[31:30];
               end else begin
                  result.immediate = {{55{w[20]}}, w[20:12]};
               end
            end else begin
               result.load_form = FORM_LITERAL;
            end
         end
         default: begin
            result.kind = KIND_UNKNOWN;
         end
      endcase
   end

endmodule

FILE: hdl/arm64_insn_classify_imm.sv
// Top level of the AArch64 instruction classifier.
// Depends on aic_pkg, aic_in_stage, aic_decode and assert_macros.svh.
//
// Usage:
//   req_* carries one instruction word and its unslid address per word;
//   it is taken at a rising edge with req_valid and req_ready both high.
//   rsp_* carries one result word per request, in order, taken at a rising
//   edge with rsp_valid and rsp_ready both high.
//   csr_wr_en/csr_wr_data write the load slide that is added to the address
//   to form pc; write it only while no word is in flight.
//   A word taken on req_* passes through the input register and then the
//   result register before it shows on rsp_*.
//   Throughput: one word per cycle unless the receiver stalls; the decode
//   and adrp page add sit between the two, the pc add before the first.
//   Reset clears both valid flags and sets the slide to zero.
//   When the receiver stalls, the result register holds its word, the input
//   register holds one more, and req_ready drops once both are full.
`include "assert_macros.svh"
module arm64_insn_classify_imm
   import aic_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_instr_word,
   input  logic [63:0]        req_location,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [3:0]         rsp_kind,
   output logic [1:0]         rsp_load_form,
   output logic               rsp_is_branch_imm,
   output logic signed [63:0] rsp_immediate,
   output logic               rsp_imm_valid,
   output logic [4:0]         rsp_dest_reg,
   output logic               rsp_dest_valid,
   output logic [4:0]         rsp_base_reg,
   output logic               rsp_base_valid,
   output logic [4:0]         rsp_test_reg,
   output logic               rsp_test_valid,
   input  logic               csr_wr_en,
   input  logic [63:0]        csr_wr_data
);

   logic [63:0] slide_ff;
   logic        stage_valid;
   stage_type   stage;
   result_type  decoded;
   logic        out_valid_ff, out_valid_in;
   result_type  out_ff;
   logic        out_load;

   // Hold the slide register
   always_ff @(posedge clock) begin
      if (reset) begin
         slide_ff <= '0;
      end else if (csr_wr_en) begin
         slide_ff <= csr_wr_data;
      end
   end

   assign out_load = stage_valid && (!out_valid_ff || rsp_ready);

   aic_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_instr_word (req_instr_word),
      .req_location   (req_location),
      .slide          (slide_ff),
      .take           (out_load),
      .stage_valid    (stage_valid),
      .stage          (stage)
   );

   aic_decode u_decode (
      .stage  (stage),
      .result (decoded)
   );

   // Advance the result register, hold it while stalled
   assign out_valid_in = out_load || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= decoded;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_kind          = out_ff.kind;
   assign rsp_load_form     = out_ff.load_form;
   assign rsp_is_branch_imm = out_ff.is_branch_imm;
   assign rsp_immediate     = signed'(out_ff.immediate);
   assign rsp_imm_valid     = out_ff.imm_valid;
   assign rsp_dest_reg      = out_ff.dest_reg;
   assign rsp_dest_valid    = out_ff.dest_valid;
   assign rsp_base_reg      = out_ff.base_reg;
   assign rsp_base_valid    = out_ff.base_valid;
   assign rsp_test_reg      = out_ff.test_reg;
   assign rsp_test_valid    = out_ff.test_valid;

   // A word waiting behind a stalled result must not be dropped
   `AIC_ASSERT(a_stage_kept, clock, reset, (stage_valid && rsp_valid && !rsp_ready) |=> stage_valid, "input stage word lost while result stalled")
   // Destination register only for adrp and add
   `AIC_ASSERT(a_dest_class, clock, reset, rsp_valid |-> (rsp_dest_valid == (rsp_kind == KIND_ADRP || rsp_kind == KIND_ADD)), "dest_valid disagrees with kind")
   // Load form is general unless the word is a load
   `AIC_ASSERT(a_form_ldr, clock, reset, (rsp_valid && rsp_load_form != FORM_GENERAL) |-> (rsp_kind == KIND_LDR), "load form set for a non-load")
   // No immediate means a zero immediate
   `AIC_ASSERT(a_imm_zero, clock, reset, (rsp_valid && !rsp_imm_valid) |-> (rsp_immediate == 64'sd0), "immediate nonzero without imm_valid")
   // Result valid is clear right after reset
   `AIC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule
